>>> src/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants of the priority task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int unsigned TaskCountDefault = 8;
  localparam int unsigned PrioBitsDefault  = 4;
  localparam int unsigned SpWidth          = 32;
  localparam int unsigned SlotWidth        = 3;
  localparam int unsigned PrioInWidth      = 4;

  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_SWITCH  = 2'd1,
    FUNC_DELAY   = 2'd2,
    FUNC_INSTALL = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEAD_RD,
    ST_HEAD_WAIT,
    ST_HEAD_USE,
    ST_TICK_RD,
    ST_TICK_WR,
    ST_PAIR_RD,
    ST_PAIR_WAIT,
    ST_PAIR_CMP,
    ST_PAIR_WR,
    ST_OUT_RD,
    ST_OUT_WAIT,
    ST_OUT_LD,
    ST_OUT
  } state_e;

endpackage

>>> src/priority_task_scheduler.sv
// ----------------------------------------------------------------------------
// priority_task_scheduler
// Task scheduler: task records and the order list in synchronous memories,
// a sequencer that reads, modifies and writes them back.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one item: tick, switch,
//   delay of the head task or task install. Every item gives one result on
//   the output channel (out_valid_o/out_ready_i): head task, its saved
//   stack pointer and the list-built flag.
//   One item is worked at a time. A tick visits each record in turn.
//   A switch updates the head record or, on the first switch, writes the
//   list 0..TaskCount-1, then runs bubble passes: each pair compare reads
//   both order entries, reads both records, compares and writes back, and
//   a switch runs up to TaskCount-1 passes. After the result is taken the
//   block returns to idle before the next intake. Reset clears all records
//   (valid bits) and the list-built flag; the block accepts items right
//   after reset. A finished result sits in an output register; while the
//   receiver stalls no new item is accepted.
// ----------------------------------------------------------------------------
module priority_task_scheduler import pts_pkg::*; #(
  parameter int unsigned TaskCount = TaskCountDefault,
  parameter int unsigned PrioBits  = PrioBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             func_i,
  input  logic [SpWidth-1:0]     current_sp_i,
  input  logic [SpWidth-1:0]     delay_ticks_i,
  input  logic [SlotWidth-1:0]   task_slot_i,
  input  logic [SpWidth-1:0]     initial_sp_i,
  input  logic [PrioInWidth-1:0] task_priority_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SpWidth-1:0]     next_sp_o,
  output logic [SlotWidth-1:0]   head_task_o,
  output logic                   list_ready_o
);

  localparam int unsigned IdxW = (TaskCount > 1) ? $clog2(TaskCount) : 1;
  localparam int unsigned RecW = 1 + SpWidth + SpWidth + PrioBits;

  // record layout: {blocked, count, sp, prio}
  typedef struct packed {
    logic                blk;
    logic [SpWidth-1:0]  cnt;
    logic [SpWidth-1:0]  sp;
    logic [PrioBits-1:0] prio;
  } rec_t;

  state_e state_q, state_d;

  // latched item
  logic [1:0]             func_q;
  logic [SpWidth-1:0]     sp_in_q, ticks_q;
  logic [SlotWidth-1:0]   slot_q;
  logic [PrioInWidth-1:0] prio_q;

  logic built_q, built_d;
  logic [IdxW:0] i_q, i_d;         // pair/entry index
  logic [IdxW:0] pass_q, pass_d;
  logic swapped_q, swapped_d;
  logic pair_sw_q;                 // current pair swapped
  logic [IdxW-1:0] a_q, a_d, b_q, b_d;
  logic [IdxW-1:0] head_q, head_d;

  logic [SpWidth-1:0]   osp_q, osp_d;
  logic [SlotWidth-1:0] ohead_q, ohead_d;
  logic                 olist_q, olist_d;

  // memory ports
  logic t_we;
  logic [IdxW-1:0] t_wa, t_ra, t_rb;
  rec_t t_wd, t_da, t_db;
  logic o_we;
  logic [IdxW-1:0] o_wa, o_wd, o_ra, o_rb, o_da, o_db;

  pts_task_mem #(.TaskCount(TaskCount), .RecWidth(RecW)) u_tmem (
    .clk_i, .rst_ni,
    .we_i(t_we), .waddr_i(t_wa), .wdata_i(t_wd),
    .raddr_a_i(t_ra), .raddr_b_i(t_rb),
    .rdata_a_o(t_da), .rdata_b_o(t_db)
  );

  pts_order_mem #(.TaskCount(TaskCount)) u_omem (
    .clk_i,
    .we_i(o_we), .waddr_i(o_wa), .wdata_i(o_wd),
    .raddr_a_i(o_ra), .raddr_b_i(o_rb),
    .rdata_a_o(o_da), .rdata_b_o(o_db)
  );

  // pair compare
  logic prio_w, do_swap;
  always_comb begin
    prio_w = (t_da.prio < t_db.prio) ||
             ((t_da.prio == t_db.prio) && (pass_q == '0));
    if (t_da.blk != t_db.blk)      do_swap = !t_db.blk;
    else if (!t_da.blk)            do_swap = prio_w;
    else if (t_da.cnt != t_db.cnt) do_swap = t_da.cnt > t_db.cnt;
    else                           do_swap = prio_w;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign next_sp_o   = osp_q;
  assign head_task_o = ohead_q;
  assign list_ready_o = olist_q;

  logic [IdxW:0] last_idx;
  assign last_idx = (IdxW+1)'(TaskCount - 1);

  // sequencer
  always_comb begin
    state_d = state_q; built_d = built_q; i_d = i_q; pass_d = pass_q;
    swapped_d = swapped_q; a_d = a_q; b_d = b_q; head_d = head_q;
    osp_d = osp_q; ohead_d = ohead_q; olist_d = olist_q;
    t_we = 1'b0; t_wa = '0; t_wd = t_da; t_ra = '0; t_rb = '0;
    o_we = 1'b0; o_wa = '0; o_wd = '0; o_ra = '0; o_rb = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          i_d = '0;
          case (func_e'(func_i))
            FUNC_TICK:    state_d = ST_TICK_RD;
            FUNC_SWITCH:  state_d = ST_HEAD_RD;
            FUNC_DELAY:   state_d = built_q ? ST_HEAD_RD : ST_OUT_RD;
            default:      state_d = ST_HEAD_RD;
          endcase
        end
      end
      // install, list build on the first switch, or head lookup
      ST_HEAD_RD: begin
        if (func_e'(func_q) == FUNC_INSTALL) begin
          if (32'(slot_q) < 32'(TaskCount)) begin
            t_ra    = IdxW'(slot_q);
            head_d  = IdxW'(slot_q);
            state_d = ST_HEAD_WAIT;
          end else begin
            state_d = ST_OUT_RD;
          end
        end else if (func_e'(func_q) == FUNC_SWITCH && !built_q) begin
          o_we = 1'b1; o_wa = i_q[IdxW-1:0]; o_wd = i_q[IdxW-1:0];
          if (i_q == last_idx) begin
            built_d = 1'b1; i_d = '0; pass_d = '0; swapped_d = 1'b0;
            state_d = ST_PAIR_RD;
          end else begin
            i_d = i_q + 1'b1;
          end
        end else begin
          o_ra = '0;
          state_d = ST_HEAD_WAIT;
        end
      end
      ST_HEAD_WAIT: begin
        if (func_e'(func_q) != FUNC_INSTALL) begin
          head_d = o_da;
          t_ra   = o_da;
        end else begin
          t_ra   = head_q;
        end
        state_d = ST_HEAD_USE;
      end
      ST_HEAD_USE: begin
        t_we = 1'b1; t_wa = head_q; t_wd = t_da;
        case (func_e'(func_q))
          FUNC_INSTALL: begin
            t_wd.sp = sp_in_q; t_wd.blk = 1'b0;
            t_wd.prio = PrioBits'(prio_q);
          end
          FUNC_DELAY: begin
            if (ticks_q != '0) begin
              t_wd.blk = 1'b1; t_wd.cnt = ticks_q;
            end
          end
          default: t_wd.sp = sp_in_q;
        endcase
        i_d = '0; pass_d = '0; swapped_d = 1'b0;
        state_d = (func_e'(func_q) == FUNC_SWITCH) ? ST_PAIR_RD : ST_OUT_RD;
      end
      // tick: read each record, write back blocked ones with a decremented count
      ST_TICK_RD: begin
        t_ra = i_q[IdxW-1:0];
        state_d = ST_TICK_WR;
      end
      ST_TICK_WR: begin
        t_wd = t_da;
        if (t_da.blk && t_da.cnt != '0) begin
          t_we = 1'b1; t_wa = i_q[IdxW-1:0];
          t_wd.cnt = t_da.cnt - 1'b1;
          if (t_da.cnt == SpWidth'(1)) t_wd.blk = 1'b0;
        end
        if (i_q == last_idx) state_d = ST_OUT_RD;
        else begin
          i_d = i_q + 1'b1; state_d = ST_TICK_RD;
        end
      end
      // bubble pass
      ST_PAIR_RD: begin
        o_ra = i_q[IdxW-1:0];
        o_rb = IdxW'(i_q + 1'b1);
        state_d = ST_PAIR_WAIT;
      end
      ST_PAIR_WAIT: begin
        a_d = o_da; b_d = o_db;
        t_ra = o_da; t_rb = o_db;
        state_d = ST_PAIR_CMP;
      end
      ST_PAIR_CMP: begin
        if (do_swap) begin
          swapped_d = 1'b1;
          o_we = 1'b1; o_wa = i_q[IdxW-1:0]; o_wd = b_q;
          state_d = ST_PAIR_WR;
        end else begin
          state_d = ST_PAIR_WR;
        end
      end
      ST_PAIR_WR: begin
        if (pair_sw_q) begin
          o_we = 1'b1; o_wa = IdxW'(i_q + 1'b1); o_wd = a_q;
        end
        if (i_q + 1'b1 == last_idx) begin
          if (!swapped_q || pass_q + 1'b1 == last_idx) state_d = ST_OUT_RD;
          else begin
            pass_d = pass_q + 1'b1; swapped_d = 1'b0; i_d = '0;
            state_d = ST_PAIR_RD;
          end
        end else begin
          i_d = i_q + 1'b1; state_d = ST_PAIR_RD;
        end
      end
      // result
      ST_OUT_RD: begin
        o_ra = '0;
        state_d = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        t_ra = built_q ? o_da : '0; head_d = o_da;
        state_d = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        osp_d = built_q ? t_da.sp : '0;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (state_q == ST_OUT_WAIT) begin
      ohead_d = SlotWidth'(o_da);
      olist_d = built_q;
      if (!built_q) ohead_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      built_q <= 1'b0;
      i_q <= '0; pass_q <= '0; pair_sw_q <= 1'b0;
    end else begin
      state_q <= state_d;
      built_q <= built_d;
      i_q <= i_d; pass_q <= pass_d;
      pair_sw_q <= (state_q == ST_PAIR_CMP) ? do_swap : pair_sw_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      func_q <= func_i; ticks_q <= delay_ticks_i;
      slot_q <= task_slot_i; prio_q <= task_priority_i;
      sp_in_q <= (func_e'(func_i) == FUNC_SWITCH) ? current_sp_i : initial_sp_i;
    end
    swapped_q <= swapped_d;
    a_q <= a_d;
    b_q <= b_d;
    head_q <= head_d;
    ohead_q <= ohead_d; olist_q <= olist_d;
    osp_q <= osp_d;
  end

endmodule

>>> src/pts_task_mem.sv
// ----------------------------------------------------------------------------
// pts_task_mem
// Task record memory: one write port, two registered read ports.
// Valid bits make unwritten records read as cleared.
// ----------------------------------------------------------------------------
module pts_task_mem import pts_pkg::*; #(
  parameter int unsigned TaskCount = TaskCountDefault,
  parameter int unsigned RecWidth  = 69,
  localparam int unsigned IdxW     = (TaskCount > 1) ? $clog2(TaskCount) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [IdxW-1:0]     waddr_i,
  input  logic [RecWidth-1:0] wdata_i,
  input  logic [IdxW-1:0]     raddr_a_i,
  input  logic [IdxW-1:0]     raddr_b_i,
  output logic [RecWidth-1:0] rdata_a_o,
  output logic [RecWidth-1:0] rdata_b_o
);

  logic [RecWidth-1:0] mem [TaskCount];
  logic [TaskCount-1:0] vld_q;
  logic [RecWidth-1:0] ra_q, rb_q;
  logic va_q, vb_q;

  // storage
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    ra_q <= mem[raddr_a_i];
    rb_q <= mem[raddr_b_i];
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      va_q  <= 1'b0;
      vb_q  <= 1'b0;
    end else begin
      if (we_i) vld_q[waddr_i] <= 1'b1;
      va_q <= vld_q[raddr_a_i];
      vb_q <= vld_q[raddr_b_i];
    end
  end

  assign rdata_a_o = va_q ? ra_q : '0;
  assign rdata_b_o = vb_q ? rb_q : '0;

endmodule

>>> src/pts_order_mem.sv
// ----------------------------------------------------------------------------
// pts_order_mem
// Order list memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module pts_order_mem import pts_pkg::*; #(
  parameter int unsigned TaskCount = TaskCountDefault,
  localparam int unsigned IdxW     = (TaskCount > 1) ? $clog2(TaskCount) : 1
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  logic [IdxW-1:0] wdata_i,
  input  logic [IdxW-1:0] raddr_a_i,
  input  logic [IdxW-1:0] raddr_b_i,
  output logic [IdxW-1:0] rdata_a_o,
  output logic [IdxW-1:0] rdata_b_o
);

  logic [IdxW-1:0] mem [TaskCount];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

>>> src/pts_checker.sv
// ----------------------------------------------------------------------------
// pts_checker
// Port-level checks of the priority task scheduler.
// ----------------------------------------------------------------------------
module pts_checker import pts_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [SlotWidth-1:0] head_task_o,
  input logic                 list_ready_o
);

  // one item at a time: no intake while a result waits
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("intake while result pending");

  // an accepted item makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("intake right after an accepted item");

  // stalled result stays valid with a stable head task
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(head_task_o))
    else $error("result changed under stall");

  // list flag does not drop while a result is held
  a_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && list_ready_o |=> !out_valid_o || list_ready_o)
    else $error("list flag dropped");

  // no head before list built
  a_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !list_ready_o |-> head_task_o == '0)
    else $error("head reported before list built");

endmodule

bind priority_task_scheduler pts_checker u_pts_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .head_task_o, .list_ready_o
);

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the priority task scheduler. A short directed table (boundary
// values, every kind of item, the cases before the first switch) is followed
// by random well-formed scheduling traffic. Every accepted item is run
// through a behavioral copy of the scheduler. Each result is compared field
// by field with the oldest expected head record.
// ----------------------------------------------------------------------------
module tb_top;
  import pts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTASK     = 8;
  localparam int RAND_ITEMS = 1200;

  typedef struct packed {
    func_e       fn;
    logic [31:0] cur_sp;
    logic [31:0] ticks;
    logic [2:0]  slot;
    logic [31:0] init_sp;
    logic [3:0]  prio;
  } sched_item_t;

  typedef struct packed {
    logic [31:0] sp;
    logic [2:0]  head;
    logic        built;
  } head_rec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func_i = FUNC_TICK;
  logic [31:0] current_sp_i = '0;
  logic [31:0] delay_ticks_i = '0;
  logic [2:0]  task_slot_i = '0;
  logic [31:0] initial_sp_i = '0;
  logic [3:0]  task_priority_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] next_sp_o;
  logic [2:0]  head_task_o;
  logic        list_ready_o;

  priority_task_scheduler dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i, .current_sp_i,
    .delay_ticks_i, .task_slot_i, .initial_sp_i, .task_priority_i,
    .out_valid_o, .out_ready_i, .next_sp_o, .head_task_o, .list_ready_o
  );

  // Scheduler copy used for prediction
  logic [2:0]  m_order [NTASK];
  logic        m_blk   [NTASK];
  logic [31:0] m_cnt   [NTASK];
  logic [31:0] m_sp    [NTASK];
  logic [3:0]  m_prio  [NTASK];
  logic        m_built;

  head_rec_t   exp_heads [$];
  int          n_err = 0;
  int          tx_idle = 23;
  int          rx_idle = 79;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit prio_first(logic [2:0] a, logic [2:0] b, int pass);
    return (m_prio[a] < m_prio[b]) || (m_prio[a] == m_prio[b] && pass == 0);
  endfunction

  function automatic bit need_swap(logic [2:0] a, logic [2:0] b, int pass);
    if (m_blk[a] != m_blk[b]) return !m_blk[b];
    if (!m_blk[a]) return prio_first(a, b, pass);
    if (m_cnt[a] != m_cnt[b]) return m_cnt[a] > m_cnt[b];
    return prio_first(a, b, pass);
  endfunction

  // Apply one item to the copy and return the head record it reports
  function automatic head_rec_t schedule(sched_item_t it);
    head_rec_t r;
    logic [2:0] t;
    bit swapped;
    case (it.fn)
      FUNC_TICK: begin
        for (int i = 0; i < NTASK; i++)
          if (m_blk[i] && m_cnt[i] != 0) begin
            m_cnt[i]--;
            if (m_cnt[i] == 0) m_blk[i] = 1'b0;
          end
      end
      FUNC_SWITCH: begin
        if (!m_built) begin
          for (int i = 0; i < NTASK; i++) m_order[i] = i[2:0];
          m_built = 1'b1;
        end else begin
          m_sp[m_order[0]] = it.cur_sp;
        end
        for (int p = 0; p < NTASK - 1; p++) begin
          swapped = 1'b0;
          for (int i = 0; i < NTASK - 1; i++)
            if (need_swap(m_order[i], m_order[i+1], p)) begin
              t = m_order[i];
              m_order[i] = m_order[i+1];
              m_order[i+1] = t;
              swapped = 1'b1;
            end
          if (!swapped) break;
        end
      end
      FUNC_DELAY: begin
        if (it.ticks != 0 && m_built) begin
          m_blk[m_order[0]] = 1'b1;
          m_cnt[m_order[0]] = it.ticks;
        end
      end
      default: begin
        m_sp[it.slot] = it.init_sp;
        m_blk[it.slot] = 1'b0;
        m_prio[it.slot] = it.prio;
      end
    endcase
    if (m_built) r = '{sp: m_sp[m_order[0]], head: m_order[0], built: 1'b1};
    else r = '0;
    return r;
  endfunction

  // Drive one item and hold it until accepted; then update the prediction
  task automatic send_item(sched_item_t it, bit fixed, head_rec_t fixed_res);
    head_rec_t r;
    in_valid_i      <= 1'b1;
    func_i          <= it.fn;
    current_sp_i    <= it.cur_sp;
    delay_ticks_i   <= it.ticks;
    task_slot_i     <= it.slot;
    initial_sp_i    <= it.init_sp;
    task_priority_i <= it.prio;
    do @(posedge clk_i); while (!in_ready_o);
    r = schedule(it);
    exp_heads.push_back(fixed ? fixed_res : r);
    // random gap after the item
    while ($urandom_range(99) < tx_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Receiver: check results, stall at random
  always @(posedge clk_i) begin
    head_rec_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (exp_heads.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result sp=%h head=%0d rdy=%0d",
                                    next_sp_o, head_task_o, list_ready_o);
        end else begin
          e = exp_heads.pop_front();
          if (e.sp !== next_sp_o || e.head !== head_task_o ||
              e.built !== list_ready_o) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch: exp sp=%h head=%0d rdy=%0d got sp=%h head=%0d rdy=%0d",
                       e.sp, e.head, e.built, next_sp_o, head_task_o, list_ready_o);
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= rx_idle);
    end
  end

  function automatic sched_item_t mk(func_e fn, logic [31:0] csp, logic [31:0] dly,
                                     logic [2:0] slot, logic [31:0] isp, logic [3:0] pr);
    return '{fn: fn, cur_sp: csp, ticks: dly, slot: slot, init_sp: isp, prio: pr};
  endfunction

  function automatic sched_item_t rand_item();
    sched_item_t it;
    int k;
    it = mk(FUNC_TICK, $urandom, 32'd0, 3'($urandom_range(7)), $urandom,
            4'($urandom_range(15)));
    k = $urandom_range(99);
    if (k < 30) it.fn = FUNC_TICK;
    else if (k < 60) it.fn = FUNC_SWITCH;
    else if (k < 80) begin
      it.fn = FUNC_DELAY;
      case ($urandom_range(9))
        0: it.ticks = $urandom;
        1: it.ticks = 32'd0;
        default: it.ticks = $urandom_range(12, 1);
      endcase
    end else it.fn = FUNC_INSTALL;
    // concentrate priorities so ties are common
    if ($urandom_range(1)) it.prio = 4'($urandom_range(3));
    return it;
  endfunction

  // Stimulus
  initial begin
    sched_item_t dir_tab [$];
    bit          dir_fix [$];
    for (int i = 0; i < NTASK; i++) begin
      m_order[i] = i[2:0]; m_blk[i] = 1'b0; m_cnt[i] = '0; m_sp[i] = '0;
      m_prio[i] = '0;
    end
    m_built = 1'b0;

    // directed rows; fixed rows all report the empty head record
    dir_tab = '{
      mk(FUNC_TICK,    32'hFFFFFFFF, 32'hFFFFFFFF, 3'd7, 32'hFFFFFFFF, 4'hF),
      mk(FUNC_DELAY,   32'h0,        32'hFFFFFFFF, 3'd0, 32'h0,        4'h0),
      mk(FUNC_SWITCH,  32'hFFFFFFFF, 32'h0,        3'd0, 32'h0,        4'h0),
      mk(FUNC_INSTALL, 32'h0,        32'h0,        3'd0, 32'hFFFFFFFF, 4'hF),
      mk(FUNC_INSTALL, 32'h0,        32'h0,        3'd7, 32'h00000000, 4'h0),
      mk(FUNC_INSTALL, 32'h0,        32'h0,        3'd3, 32'hA5A5A5A5, 4'h8),
      mk(FUNC_INSTALL, 32'h0,        32'h0,        3'd5, 32'h5A5A5A5A, 4'h8),
      mk(FUNC_SWITCH,  32'h12345678, 32'h0,        3'd0, 32'h0,        4'h0),
      mk(FUNC_SWITCH,  32'hFFFFFFFF, 32'h0,        3'd0, 32'h0,        4'h0),
      mk(FUNC_DELAY,   32'h0,        32'h0,        3'd0, 32'h0,        4'h0),
      mk(FUNC_DELAY,   32'h0,        32'hFFFFFFFF, 3'd0, 32'h0,        4'h0),
      mk(FUNC_SWITCH,  32'h00000000, 32'h0,        3'd0, 32'h0,        4'h0),
      mk(FUNC_DELAY,   32'h0,        32'd2,        3'd0, 32'h0,        4'h0),
      mk(FUNC_SWITCH,  32'h0BADF00D, 32'h0,        3'd0, 32'h0,        4'h0),
      mk(FUNC_DELAY,   32'h0,        32'd2,        3'd0, 32'h0,        4'h0),
      mk(FUNC_SWITCH,  32'hCAFE0000, 32'h0,        3'd0, 32'h0,        4'h0),
      mk(FUNC_TICK,    32'h0,        32'h0,        3'd0, 32'h0,        4'h0),
      mk(FUNC_SWITCH,  32'h1,        32'h0,        3'd0, 32'h0,        4'h0),
      mk(FUNC_TICK,    32'h0,        32'h0,        3'd0, 32'h0,        4'h0),
      mk(FUNC_SWITCH,  32'h2,        32'h0,        3'd0, 32'h0,        4'h0),
      mk(FUNC_INSTALL, 32'h0,        32'h0,        3'd0, 32'h00000010, 4'h1),
      mk(FUNC_SWITCH,  32'h3,        32'h0,        3'd0, 32'h0,        4'h0)
    };
    dir_fix = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_item(dir_tab[i], dir_fix[i], '0);

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 23 : (ph == 1) ? 79 : 0;
      rx_idle = (ph == 0) ? 79 : (ph == 1) ? 23 : 0;
      for (int k = 0; k < RAND_ITEMS / 3; k++) send_item(rand_item(), 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    wait (exp_heads.size() == 0);
    repeat (300) @(posedge clk_i);
    if (n_err == 0 && exp_heads.size() == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

  // Watchdog
  initial begin
    #15ms;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

>>> sim.f
src/pts_pkg.sv
src/pts_task_mem.sv
src/pts_order_mem.sv
src/priority_task_scheduler.sv
src/pts_checker.sv
verif/tb_top.sv
